[sv/ufs_pkg.sv]
// ----------------------------------------------------------------------------
// ufs_pkg: shared types and constants of the url field splitter
// parse modes, status codes, parser state and result layouts
// ----------------------------------------------------------------------------
package ufs_pkg;

   // longest accepted string is MAX_LEN-1 bytes before the NUL
   localparam int MAX_LEN = 4096;
   localparam int POS_W   = $clog2(MAX_LEN);
   localparam int FLD_W   = 12;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [FLD_W-1:0] fld_type;

   localparam pos_type POS_LAST = pos_type'(MAX_LEN - 1);

   // parse modes
   localparam logic [2:0] MODE_START  = 3'd0;
   localparam logic [2:0] MODE_TEXT   = 3'd1;
   localparam logic [2:0] MODE_SLASH1 = 3'd2;
   localparam logic [2:0] MODE_SLASH2 = 3'd3;
   localparam logic [2:0] MODE_PROTO  = 3'd4;
   localparam logic [2:0] MODE_MAILTO = 3'd5;
   localparam logic [2:0] MODE_HOST   = 3'd6;
   localparam logic [2:0] MODE_PATH   = 3'd7;

   // mailto prefix tracker
   localparam logic [2:0] MATCH_FULL = 3'd6;
   localparam logic [2:0] MATCH_NONE = 3'd7;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SYNTAX  = 2'd1;
   localparam logic [1:0] STATUS_OVERLEN = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   typedef struct packed {
      logic [2:0] mode;
      pos_type    position;
      pos_type    token_start;
      pos_type    proto_length;
      pos_type    host_begin;
      pos_type    host_length;
      logic [2:0] mailto_match;
      logic       colon_pending;
      logic       skip_to_end;
   } state_type;

   typedef struct packed {
      logic [1:0] status;
      logic       is_mailto;
      fld_type    protocol_len;
      fld_type    host_start;
      fld_type    host_len;
      fld_type    path_start;
      fld_type    path_len;
      fld_type    end_pos;
   } result_type;

   // letters of "mailto" by index
   function automatic logic [7:0] mailto_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h6D;
         3'd1:    ch = 8'h61;
         3'd2:    ch = 8'h69;
         3'd3:    ch = 8'h6C;
         3'd4:    ch = 8'h74;
         3'd5:    ch = 8'h6F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // offset to the 12-bit result field width
   function automatic fld_type to_fld(input pos_type v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[FLD_W-1:0];
   endfunction

endpackage

[sv/ufs_if.sv]
// ----------------------------------------------------------------------------
// ufs_if: stream channels of the url field splitter
// byte request channel and field result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface ufs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface ufs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        is_mailto;
   logic [11:0] protocol_len;
   logic [11:0] host_start;
   logic [11:0] host_len;
   logic [11:0] path_start;
   logic [11:0] path_len;
   logic [11:0] end_pos;

   modport source (output valid, output status, output is_mailto, output protocol_len,
                   output host_start, output host_len, output path_start,
                   output path_len, output end_pos, input ready);
   modport sink   (input valid, input status, input is_mailto, input protocol_len,
                   input host_start, input host_len, input path_start,
                   input path_len, input end_pos, output ready);
endinterface

[sv/url_field_splitter_unit.sv]
// ----------------------------------------------------------------------------
// url_field_splitter_unit: streaming url field splitter
// splits a NUL-terminated url, one byte per transaction, into protocol,
// host and path offsets and lengths
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                                  | transaction
//  ---------+-----------+------------------------------------------+-------------------------
//  req_chan | in        | char_code                                | one url byte
//  rsp_chan | out       | status, is_mailto, protocol_len, host_*, | one result per string,
//           |           | path_*, end_pos                          | or per error/overlength
//
//  one byte accepted every cycle while no result stalls; a result passes the
//  input register, then the result register after the parse step logic
//  synchronous active-high reset returns the parser to its start state
//  a stalled result holds in the result register; one more byte still lands
//  in the input register and waits there until the result is taken
//
module url_field_splitter_unit
   import ufs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ufs_req_if.sink       req_chan,
   ufs_rsp_if.source     rsp_chan
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_char_ff;

   // parser state
   state_type  state_ff;
   state_type  state_in;

   // result register
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_data_ff;

   logic       step_valid;
   result_type step_result;
   logic       advance;
   logic       req_take;

   // the step stage moves whenever the result register is free or draining
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   ufs_parse_step u_step (
      .state_now    (state_ff),
      .char_code    (in_char_ff),
      .state_next   (state_in),
      .result_valid (step_valid),
      .result       (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && in_valid_ff && step_valid) begin
         out_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.char_code;
      end
      if (advance && in_valid_ff && step_valid) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_data_ff.status;
   assign rsp_chan.is_mailto    = out_data_ff.is_mailto;
   assign rsp_chan.protocol_len = out_data_ff.protocol_len;
   assign rsp_chan.host_start   = out_data_ff.host_start;
   assign rsp_chan.host_len     = out_data_ff.host_len;
   assign rsp_chan.path_start   = out_data_ff.path_start;
   assign rsp_chan.path_len     = out_data_ff.path_len;
   assign rsp_chan.end_pos      = out_data_ff.end_pos;

endmodule

[sv/ufs_parse_step.sv]
// ----------------------------------------------------------------------------
// ufs_parse_step: one byte of the url parse
// next parser state and the optional result for one input byte
// ----------------------------------------------------------------------------
module ufs_parse_step
   import ufs_pkg::*;
(
   input  state_type  state_now,
   input  logic [7:0] char_code,
   output state_type  state_next,
   output logic       result_valid,
   output result_type result
);

   function automatic logic [2:0] feed_match(input logic [2:0] m, input pos_type idx,
                                             input logic [7:0] ch);
      logic [2:0] r;
      if (idx == pos_type'(m) && m < MATCH_FULL && ch == mailto_char(m)) begin
         r = m + 3'd1;
      end else begin
         r = MATCH_NONE;
      end
      return r;
   endfunction

   always_comb begin
      state_type  s;
      pos_type    pos;
      pos_type    plen;
      logic       is_end;
      logic       is_ws;
      logic       is_digit;
      logic       failed;

      s            = state_now;
      pos          = state_now.position;
      plen         = '0;
      is_end       = (char_code == CHAR_NUL);
      is_ws        = char_code inside {8'h20, 8'h09, 8'h0A, 8'h0D};
      is_digit     = char_code inside {[8'h30:8'h39]};
      failed       = 1'b0;
      result_valid = 1'b0;
      result       = '0;

      if (state_now.skip_to_end) begin
         if (is_end) begin
            s = '0;
         end
      end else if (!is_end && pos >= POS_LAST) begin
         result_valid  = 1'b1;
         result.status = STATUS_OVERLEN;
         s.skip_to_end = 1'b1;
      end else begin
         // colon is a port separator only if a digit follows it
         if (s.colon_pending) begin
            s.colon_pending = 1'b0;
            if (is_digit) begin
               s.mailto_match = MATCH_NONE;
            end else begin
               s.proto_length = pos - pos_type'(1);
               s.token_start  = pos - pos_type'(1);
               s.mode         = MODE_SLASH1;
            end
         end

         case (s.mode)
            MODE_START: begin
               if (char_code == CHAR_SLASH) begin
                  s.token_start = pos;
                  s.mode        = MODE_PATH;
               end else if (char_code == CHAR_COLON || is_end || is_ws) begin
                  failed = 1'b1;
               end else begin
                  s.token_start  = pos;
                  s.mode         = MODE_TEXT;
                  s.mailto_match = feed_match(s.mailto_match, '0, char_code);
               end
            end
            MODE_TEXT: begin
               if (char_code == CHAR_SLASH || is_end || is_ws) begin
                  s.host_begin  = s.token_start;
                  s.host_length = pos - s.token_start;
                  s.token_start = pos;
                  s.mode        = MODE_PATH;
               end else if (char_code == CHAR_COLON) begin
                  if (s.mailto_match == MATCH_FULL &&
                      pos - s.token_start == pos_type'(6)) begin
                     s.proto_length = pos_type'(6);
                     s.mode         = MODE_MAILTO;
                  end else begin
                     s.colon_pending = 1'b1;
                  end
               end else begin
                  s.mailto_match = feed_match(s.mailto_match, pos - s.token_start,
                                              char_code);
               end
            end
            MODE_MAILTO: begin
               s.token_start = pos;
               s.mode        = MODE_PATH;
            end
            MODE_SLASH1: begin
               if (char_code != CHAR_SLASH) begin
                  failed = 1'b1;
               end else begin
                  s.mode = MODE_SLASH2;
               end
            end
            MODE_SLASH2: begin
               if (char_code != CHAR_SLASH) begin
                  failed = 1'b1;
               end else begin
                  s.mode = MODE_PROTO;
               end
            end
            MODE_PROTO: begin
               s.token_start = pos;
               s.mode        = (char_code == CHAR_SLASH) ? MODE_PATH : MODE_HOST;
            end
            MODE_HOST: begin
               if (char_code == CHAR_SLASH || is_end || is_ws) begin
                  s.host_begin  = s.token_start;
                  s.host_length = pos - s.token_start;
                  s.token_start = pos;
                  s.mode        = MODE_PATH;
               end
            end
            default: begin
            end
         endcase

         if (failed) begin
            result_valid  = 1'b1;
            result.status = STATUS_SYNTAX;
            if (is_end) begin
               s = '0;
            end else begin
               s.skip_to_end = 1'b1;
            end
         end else if (is_end) begin
            plen                = (s.mode == MODE_PATH) ? pos - s.token_start : '0;
            result_valid        = 1'b1;
            result.status       = STATUS_OK;
            result.is_mailto    = (s.mailto_match == MATCH_FULL) && (s.proto_length != '0);
            result.protocol_len = to_fld(s.proto_length);
            result.host_start   = (s.host_length != '0) ? to_fld(s.host_begin) : '0;
            result.host_len     = to_fld(s.host_length);
            result.path_start   = (plen != '0) ? to_fld(s.token_start) : '0;
            result.path_len     = to_fld(plen);
            result.end_pos      = to_fld(pos);
            s                   = '0;
         end else begin
            s.position = pos + pos_type'(1);
         end
      end

      state_next = s;
   end

endmodule
